// ===== hw/rtl/lge_pkg.sv =====
// ----------------------------------------------------------------------------
// Life generation engine package
// Shared constants and the per-cell rule for the B3/S23 generation engine.
// ----------------------------------------------------------------------------
package lge_pkg;

  // Field widths of the channels and the configuration port.
  localparam int MODE_W = 2;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int CFG_W  = 7;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP   = 2'd2;

  // Register indexes, taken from address bit 2.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 7'd40;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 7'd24;

  // Rule constants.
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

  // Next state of one cell from its own state and its eight neighbors.
  function automatic logic life_next(input logic alive, input logic [7:0] nbrs);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'd0, nbrs[i]};
    end
    if (alive) begin
      life_next = (cnt >= SURVIVE_LOW) && (cnt <= SURVIVE_HIGH);
    end else begin
      life_next = (cnt == BIRTH_COUNT);
    end
  endfunction

endpackage

// ===== hw/rtl/lge_in_if.sv =====
// ----------------------------------------------------------------------------
// Life generation engine command channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface lge_in_if;
  logic                     valid;
  logic                     ready;
  logic [lge_pkg::MODE_W-1:0] mode;
  logic [lge_pkg::COL_W-1:0]  col;
  logic [lge_pkg::ROW_W-1:0]  row;

  modport source (output valid, output mode, output col, output row, input ready);
  modport sink   (input valid, input mode, input col, input row, output ready);
endinterface

// ===== hw/rtl/lge_out_if.sv =====
// ----------------------------------------------------------------------------
// Life generation engine result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface lge_out_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic out_of_range;

  modport source (output valid, output cell_value, output out_of_range, input ready);
  modport sink   (input valid, input cell_value, input out_of_range, output ready);
endinterface

// ===== hw/rtl/lge_grid_mem.sv =====
// ----------------------------------------------------------------------------
// Life generation engine grid memory
// One row per word, one write and one registered read a cycle. A valid bit
// per row makes rows that were never written read as all dead after reset.
// ----------------------------------------------------------------------------
module lge_grid_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid_r;
  logic [WIDTH-1:0] rd_q_r;
  logic             rd_vld_r;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Row valid bits and the valid flag of the word being read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_valid_r[rd_addr];
      end
    end
  end

  // A row never written reads as all dead.
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== hw/rtl/lge_row_unit.sv =====
// ----------------------------------------------------------------------------
// Life generation engine row unit
// Computes the next generation of one whole row from the old rows above,
// here and below. Columns outside the active width count as dead and keep
// their stored value.
// ----------------------------------------------------------------------------
module lge_row_unit #(
  parameter int MAX_WIDTH = 64
) (
  input  logic [$clog2(MAX_WIDTH+1)-1:0] act_w,
  input  logic [MAX_WIDTH-1:0]           above,
  input  logic [MAX_WIDTH-1:0]           here,
  input  logic [MAX_WIDTH-1:0]           below,
  output logic [MAX_WIDTH-1:0]           new_row
);
  import lge_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [MAX_WIDTH-1:0] wmask;
  logic [MAX_WIDTH-1:0] ma, mh, mb;
  logic [MAX_WIDTH-1:0] al, ar, hl, hr, bl, br;

  // Window mask: one for every column in use.
  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      wmask[c] = (WW'(c) < act_w);
    end
  end

  // Masked rows and their left and right neighbor views.
  assign ma = above & wmask;
  assign mh = here & wmask;
  assign mb = below & wmask;
  assign al = {ma[MAX_WIDTH-2:0], 1'b0};
  assign ar = {1'b0, ma[MAX_WIDTH-1:1]};
  assign hl = {mh[MAX_WIDTH-2:0], 1'b0};
  assign hr = {1'b0, mh[MAX_WIDTH-1:1]};
  assign bl = {mb[MAX_WIDTH-2:0], 1'b0};
  assign br = {1'b0, mb[MAX_WIDTH-1:1]};

  // One rule lane per column.
  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      if (wmask[c]) begin
        new_row[c] = life_next(mh[c], {al[c], ma[c], ar[c], hl[c], hr[c],
                                       bl[c], mb[c], br[c]});
      end else begin
        new_row[c] = here[c];
      end
    end
  end

endmodule

// ===== hw/rtl/life_generation_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Life generation engine
// Game of Life (B3/S23) engine on a bit grid with read, toggle and step.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on in_chan (valid/ready); each transfer carries mode, col
//   and row. Mode 0 reads a cell, mode 1 toggles it, mode 2 advances the grid
//   one generation. Every command yields exactly one result on out_chan with
//   cell_value and out_of_range.
//   Read and toggle go from transfer to result through a grid memory read,
//   a state to pick the bit (and write back) and the load of the output
//   register. An out-of-range or unknown command skips the memory read.
//   A step sweeps the grid one row per cycle through the shared row unit,
//   with the grid memory read two rows ahead of the row being written.
//   The engine takes one command at a time; in_chan.ready is high only while
//   it waits for a command. The result is held in an output register, so the
//   next command is accepted while an earlier result waits to be taken; when
//   the receiver stalls longer, a finished command waits until it can load.
//   Reset clears all cells to dead (per-row valid bits, no clearing pass)
//   and sets the grid to 40 columns by 24 rows. The user must write the registers over
//   the APB port only while the engine is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module life_generation_engine_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lge_in_if.sink                      in_chan,
  lge_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lge_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [lge_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [lge_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import lge_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(MAX_HEIGHT);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CELL = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_ROW  = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     grid_width_r, grid_height_r;
  logic [WW-1:0]        act_w;
  logic [HW-1:0]        act_h;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [AW-1:0]        row_r, row_nxt;
  logic [HW-1:0]        row_cnt_r, row_cnt_nxt;
  logic [MAX_WIDTH-1:0] above_r, above_nxt;
  logic [MAX_WIDTH-1:0] here_r, here_nxt;
  logic                 res_value_r, res_value_nxt;
  logic                 res_oor_r, res_oor_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_value_r, out_value_nxt;
  logic                 out_oor_r, out_oor_nxt;

  logic                 in_acc;
  logic                 in_oor;
  logic                 cfg_wr;
  logic                 last_row;
  logic [HW:0]          row_ahead;
  logic [MAX_WIDTH-1:0] below;
  logic [MAX_WIDTH-1:0] new_row;

  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [MAX_WIDTH-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [MAX_WIDTH-1:0] mem_wr_data;

  // Grid size registers, saturated to the storage size.
  assign act_w = (32'(grid_width_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(grid_width_r);
  assign act_h = (32'(grid_height_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(grid_height_r);

  // Configuration port: always ready, write on the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RESET_WIDTH;
      grid_height_r <= RESET_HEIGHT;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_IDX_WIDTH) begin
        grid_width_r <= cfg_pwdata[CFG_W-1:0];
      end else begin
        grid_height_r <= cfg_pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      CFG_IDX_WIDTH:  cfg_prdata = APB_DW'(grid_width_r);
      CFG_IDX_HEIGHT: cfg_prdata = APB_DW'(grid_height_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Grid storage and the shared row unit.
  lge_grid_mem #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH)
  ) u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  lge_row_unit #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row (
    .act_w   (act_w),
    .above   (above_r),
    .here    (here_r),
    .below   (below),
    .new_row (new_row)
  );

  // Command handshake and range check.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && (state_r == ST_IDLE);
  assign in_oor        = (32'(in_chan.col) >= 32'(act_w)) ||
                         (32'(in_chan.row) >= 32'(act_h));

  // Sweep bookkeeping: the current row is the last one of the window.
  assign last_row  = (HW'(row_cnt_r + HW'(1)) == act_h);
  assign row_ahead = (HW+1)'(row_cnt_r) + (HW+1)'(2);
  assign below     = last_row ? '0 : mem_rd_data;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    row_cnt_nxt   = row_cnt_r;
    above_nxt     = above_r;
    here_nxt      = here_r;
    res_value_nxt = res_value_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_oor_nxt   = out_oor_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;

    // The output register empties on a result transfer.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt      = in_chan.mode;
          col_nxt       = CW'(in_chan.col);
          row_nxt       = AW'(in_chan.row);
          res_value_nxt = 1'b0;
          res_oor_nxt   = 1'b0;
          state_nxt     = ST_RESP;
          if (in_chan.mode == MODE_READ || in_chan.mode == MODE_TOGGLE) begin
            if (in_oor) begin
              res_oor_nxt = 1'b1;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = AW'(in_chan.row);
              state_nxt   = ST_CELL;
            end
          end else if (in_chan.mode == MODE_STEP) begin
            if (act_w != '0 && act_h != '0) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              above_nxt   = '0;
              row_cnt_nxt = '0;
              state_nxt   = ST_LOAD;
            end
          end
        end
      end

      ST_CELL: begin
        if (mode_r == MODE_TOGGLE) begin
          mem_wr_en     = 1'b1;
          mem_wr_addr   = row_r;
          mem_wr_data   = mem_rd_data ^ ({{(MAX_WIDTH-1){1'b0}}, 1'b1} << col_r);
          res_value_nxt = ~mem_rd_data[col_r];
        end else begin
          res_value_nxt = mem_rd_data[col_r];
        end
        state_nxt = ST_RESP;
      end

      ST_LOAD: begin
        // Row 0 has arrived; fetch row 1 if the window has one.
        here_nxt = mem_rd_data;
        if (act_h > HW'(1)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(1);
        end
        state_nxt = ST_ROW;
      end

      ST_ROW: begin
        // Write the new row, shift the old rows up and fetch two ahead.
        mem_wr_en   = 1'b1;
        mem_wr_addr = row_cnt_r[AW-1:0];
        mem_wr_data = new_row;
        above_nxt   = here_r;
        here_nxt    = below;
        if (row_ahead < (HW+1)'(act_h)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = row_ahead[AW-1:0];
        end
        if (last_row) begin
          row_cnt_nxt = '0;
          state_nxt   = ST_RESP;
        end else begin
          row_cnt_nxt = row_cnt_r + HW'(1);
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    above_r     <= above_nxt;
    here_r      <= here_nxt;
    res_value_r <= res_value_nxt;
    res_oor_r   <= res_oor_nxt;
    out_value_r <= out_value_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.cell_value   = out_value_r;
  assign out_chan.out_of_range = out_oor_r;

  // The row counter is back at zero whenever no sweep is running.
  a_row_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ROW) |-> (row_cnt_r == '0))
    else $error("row counter not cleared outside a sweep");

  // The grid is only written while a command is in progress.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_RESP || state_r == ST_LOAD) |-> !mem_wr_en)
    else $error("grid written outside a cell or row update");

  // A sweep never writes a row outside the window.
  a_sweep_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW) |-> (row_cnt_r < act_h))
    else $error("sweep row beyond grid height");

  // An accepted command always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("command accepted without leaving idle");

endmodule

// ===== tb/sv/life_generation_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life generation engine testbench
// Drives read, toggle, step and undefined commands into the engine. A shadow
// copy of the grid, or the directed table for its typed rows, predicts every
// result, and each transfer on the result channel is compared field by field.
// The grid size is changed between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module life_generation_engine_unit_tb;
  import lge_pkg::*;

  localparam int GRID_MAX = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int NUM_PHASES = 10;
  localparam int MAX_REPORTS = 20;
  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

  typedef struct packed {
    logic cell_value;
    logic out_of_range;
  } cell_result_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    bit                typed;
    logic              exp_live;
    logic              exp_oor;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  lge_in_if  cmd_bus ();
  lge_out_if res_bus ();

  life_generation_engine_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (cmd_bus),
    .out_chan    (res_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow of the engine state and the expected results in flight.
  logic [GRID_MAX-1:0] grid_shadow [GRID_MAX];
  logic [CFG_W-1:0] shadow_width;
  logic [CFG_W-1:0] shadow_height;
  cell_result_t pending_results [$];

  int error_count;
  int sent_count;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;

  // Directed commands on the reset grid of 40 by 24.
  stim_row_t directed_rows [24] = '{
    '{MODE_READ,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{MODE_READ,   6'd39, 6'd23, 1'b1, 1'b0, 1'b0},
    '{MODE_READ,   6'd63, 6'd63, 1'b1, 1'b0, 1'b1},
    '{MODE_TOGGLE, 6'd40, 6'd0,  1'b1, 1'b0, 1'b1},
    '{MODE_TOGGLE, 6'd0,  6'd24, 1'b1, 1'b0, 1'b1},
    '{MODE_TOGGLE, 6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
    '{MODE_READ,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
    '{MODE_TOGGLE, 6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{MODE_TOGGLE, 6'd39, 6'd23, 1'b1, 1'b1, 1'b0},
    '{MODE_UNDEF,  6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
    '{MODE_TOGGLE, 6'd5,  6'd5,  1'b0, 1'b0, 1'b0},
    '{MODE_TOGGLE, 6'd6,  6'd5,  1'b0, 1'b0, 1'b0},
    '{MODE_TOGGLE, 6'd7,  6'd5,  1'b0, 1'b0, 1'b0},
    '{MODE_STEP,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{MODE_READ,   6'd6,  6'd4,  1'b0, 1'b0, 1'b0},
    '{MODE_READ,   6'd6,  6'd6,  1'b0, 1'b0, 1'b0},
    '{MODE_READ,   6'd5,  6'd5,  1'b0, 1'b0, 1'b0},
    '{MODE_TOGGLE, 6'd39, 6'd22, 1'b0, 1'b0, 1'b0},
    '{MODE_TOGGLE, 6'd38, 6'd23, 1'b0, 1'b0, 1'b0},
    '{MODE_STEP,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{MODE_READ,   6'd38, 6'd22, 1'b0, 1'b0, 1'b0},
    '{MODE_READ,   6'd39, 6'd23, 1'b0, 1'b0, 1'b0},
    '{MODE_STEP,   6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
    '{MODE_READ,   6'd6,  6'd5,  1'b0, 1'b0, 1'b0}
  };

  // Grid sizes per random phase: extremes, saturation and empty windows.
  int phase_width  [NUM_PHASES] = '{8, 1, 64, 127, 0, 6, 16, 3, 64, 12};
  int phase_height [NUM_PHASES] = '{8, 1, 64, 100, 6, 0, 12, 64, 2, 12};
  int phase_items  [NUM_PHASES] = '{70, 30, 60, 40, 25, 25, 80, 40, 40, 110};

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Columns and rows in use, with oversized registers saturated.
  function automatic int live_cols();
    return (int'(shadow_width) > GRID_MAX) ? GRID_MAX : int'(shadow_width);
  endfunction

  function automatic int live_rows();
    return (int'(shadow_height) > GRID_MAX) ? GRID_MAX : int'(shadow_height);
  endfunction

  // One B3/S23 generation over the window; cells outside it stay as stored.
  function automatic void advance_shadow();
    logic [GRID_MAX-1:0] prev [GRID_MAX];
    int w;
    int h;
    int n;
    int rr;
    int cc;
    prev = grid_shadow;
    w = live_cols();
    h = live_rows();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w) begin
              n += int'(prev[rr][cc]);
            end
          end
        end
        if (prev[r][c]) begin
          grid_shadow[r][c] = (n >= int'(SURVIVE_LOW)) && (n <= int'(SURVIVE_HIGH));
        end else begin
          grid_shadow[r][c] = (n == int'(BIRTH_COUNT));
        end
      end
    end
  endfunction

  // Applies one command to the shadow grid and returns its result.
  function automatic cell_result_t life_outcome(input logic [MODE_W-1:0] mode,
                                                input logic [COL_W-1:0] col,
                                                input logic [ROW_W-1:0] row);
    cell_result_t res;
    res = '0;
    if (mode == MODE_READ || mode == MODE_TOGGLE) begin
      if (int'(col) >= live_cols() || int'(row) >= live_rows()) begin
        res.out_of_range = 1'b1;
      end else begin
        if (mode == MODE_TOGGLE) begin
          grid_shadow[row][col] = ~grid_shadow[row][col];
        end
        res.cell_value = grid_shadow[row][col];
      end
    end else if (mode == MODE_STEP) begin
      advance_shadow();
    end
    return res;
  endfunction

  // Random coordinate, mostly inside the window, sometimes anywhere.
  function automatic logic [5:0] pick_coord(input int lim);
    if (lim == 0 || $urandom_range(0, 9) == 0) begin
      return 6'($urandom_range(0, 63));
    end
    return 6'($urandom_range(0, lim - 1));
  endfunction

  // Coordinate within two cells of a center, kept inside the field range.
  function automatic logic [5:0] near_coord(input int centre);
    int v;
    v = centre + int'($urandom_range(0, 4)) - 2;
    if (v < 0) begin
      v = 0;
    end
    if (v > 63) begin
      v = 63;
    end
    return 6'(v);
  endfunction

  // Sends one command and records its expected result at the transfer.
  task automatic send_command(input logic [MODE_W-1:0] mode,
                              input logic [COL_W-1:0] col,
                              input logic [ROW_W-1:0] row,
                              input bit typed,
                              input cell_result_t want);
    cell_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      cmd_bus.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_bus.valid <= 1'b1;
    cmd_bus.mode  <= mode;
    cmd_bus.col   <= col;
    cmd_bus.row   <= row;
    do begin
      @(posedge clk);
    end while (!cmd_bus.ready);
    predicted = life_outcome(mode, col, row);
    pending_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  // Holds the command channel until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic idx, input int value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {$urandom} & ~32'h7F | (32'(value) & 32'h7F);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    if (idx == CFG_IDX_WIDTH) begin
      shadow_width = 7'(value);
    end else begin
      shadow_height = 7'(value);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Seeds a small cluster, runs a generation or two, then reads around it.
  task automatic send_cluster();
    int cw;
    int ch;
    int cx;
    int cy;
    cw = live_cols();
    ch = live_rows();
    cx = int'(pick_coord(cw));
    cy = int'(pick_coord(ch));
    repeat ($urandom_range(3, 6)) begin
      send_command(MODE_TOGGLE, near_coord(cx), near_coord(cy), 1'b0, '0);
    end
    repeat ($urandom_range(1, 2)) begin
      send_command(MODE_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   1'b0, '0);
    end
    repeat ($urandom_range(2, 4)) begin
      send_command(MODE_READ, near_coord(cx), near_coord(cy), 1'b0, '0);
    end
  endtask

  // Any command kind with coordinates over the whole field range.
  task automatic send_noise();
    int pick;
    logic [MODE_W-1:0] mode;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      mode = MODE_READ;
    end else if (pick < 7) begin
      mode = MODE_TOGGLE;
    end else if (pick < 9) begin
      mode = MODE_STEP;
    end else begin
      mode = MODE_UNDEF;
    end
    send_command(mode, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0, '0);
  endtask

  // Result receiver: ready changes at the falling edge.
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk) begin : check_result
    cell_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: result with none expected, actual value %0b oor %0b",
                   $time, res_bus.cell_value, res_bus.out_of_range);
        end
      end else begin
        want = pending_results.pop_front();
        if (res_bus.cell_value !== want.cell_value) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: cell_value mismatch, expected %0b actual %0b",
                     $time, want.cell_value, res_bus.cell_value);
          end
        end
        if (res_bus.out_of_range !== want.out_of_range) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: out_of_range mismatch, expected %0b actual %0b",
                     $time, want.out_of_range, res_bus.out_of_range);
          end
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    stim_row_t dir_row;
    int target;
    int choice;
    rst_n         <= 1'b0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.mode  <= MODE_READ;
    cmd_bus.col   <= '0;
    cmd_bus.row   <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    error_count   = 0;
    sent_count    = 0;
    send_idle_pct = 12;
    recv_idle_pct = 48;
    for (int r = 0; r < GRID_MAX; r++) begin
      grid_shadow[r] = '0;
    end
    shadow_width  = RESET_WIDTH;
    shadow_height = RESET_HEIGHT;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed commands on the reset grid.
    foreach (directed_rows[i]) begin
      dir_row = directed_rows[i];
      send_command(dir_row.mode, dir_row.col, dir_row.row, dir_row.typed,
                   '{cell_value: dir_row.exp_live, out_of_range: dir_row.exp_oor});
    end

    // Random phases, each on its own grid size.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      repeat (8) @(posedge clk);
      if (p < 3) begin
        send_idle_pct = 12;
        recv_idle_pct = 48;
      end else if (p < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_register(CFG_IDX_WIDTH, phase_width[p]);
      write_register(CFG_IDX_HEIGHT, phase_height[p]);
      target = sent_count + phase_items[p];
      while (sent_count < target) begin
        choice = $urandom_range(0, 99);
        if (choice < 3) begin
          drain_results();
        end else if (choice < 70) begin
          send_cluster();
        end else begin
          send_noise();
        end
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
